>>> hdl/cpu_opcode_predecoder_top_defines.svh
// Assertion macros shared by the predecoder modules.
`ifndef CPU_OPCODE_PREDECODER_TOP_DEFINES_SVH
`define CPU_OPCODE_PREDECODER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define COP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("cop: property failed");
`define COP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("cop: property failed");
`else
`define COP_ASSERT(lbl, prop)
`define COP_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

>>> hdl/cop_pkg.sv
`default_nettype none

package cop_pkg;

  typedef enum logic [6:0] {
    MN_ADC, MN_AND, MN_ASL, MN_BCC, MN_BCS, MN_BEQ, MN_BIT, MN_BMI, MN_BNE, MN_BPL,
    MN_BRA, MN_BRK, MN_BVC, MN_BVS, MN_CLC, MN_CLD, MN_CLI, MN_CLV, MN_CMP, MN_CPX,
    MN_CPY, MN_DEC, MN_DEX, MN_DEY, MN_EOR, MN_INC, MN_INX, MN_INY, MN_JMP, MN_JSR,
    MN_LDA, MN_LDX, MN_LDY, MN_LSR, MN_NOP, MN_ORA, MN_PHA, MN_PHP, MN_PHX, MN_PHY,
    MN_PLA, MN_PLP, MN_PLX, MN_PLY, MN_ROL, MN_ROR, MN_RTI, MN_RTS, MN_SBC, MN_SEC,
    MN_SED, MN_SEI, MN_STA, MN_STP, MN_STX, MN_STY, MN_STZ, MN_TAX, MN_TAY, MN_TRB,
    MN_TSB, MN_TSX, MN_TXA, MN_TXS, MN_TYA, MN_WAI, MN_UND
  } mnem_e;

  typedef enum logic [4:0] {
    AM_IMP   = 5'd0,
    AM_IMPA  = 5'd1,
    AM_BRA   = 5'd3,
    AM_IMM   = 5'd4,
    AM_ZP    = 5'd5,
    AM_ZPX   = 5'd6,
    AM_ZPY   = 5'd7,
    AM_INDX  = 5'd8,
    AM_INDY  = 5'd9,
    AM_IND   = 5'd10,
    AM_ABS   = 5'd12,
    AM_ABSX  = 5'd13,
    AM_ABSY  = 5'd14,
    AM_IND16 = 5'd15,
    AM_IND1X = 5'd16
  } amode_e;

  // Highest mode code of the no-operand and one-operand groups.
  localparam logic [4:0] LastNoOperand  = 5'd2;
  localparam logic [4:0] LastOneOperand = 5'd11;

  typedef struct packed {
    logic [7:0]  opcode;
    logic [15:0] addr;
    logic [7:0]  operand_lo;
    logic [7:0]  operand_hi;
  } rec_t;

  localparam mnem_e MnemTab [256] = '{
    MN_BRK, MN_ORA, MN_UND, MN_UND, MN_TSB, MN_ORA, MN_ASL, MN_UND,
    MN_PHP, MN_ORA, MN_ASL, MN_UND, MN_TSB, MN_ORA, MN_ASL, MN_UND,
    MN_BPL, MN_ORA, MN_ORA, MN_UND, MN_TRB, MN_ORA, MN_ASL, MN_UND,
    MN_CLC, MN_ORA, MN_INC, MN_UND, MN_TRB, MN_ORA, MN_ASL, MN_UND,
    MN_JSR, MN_AND, MN_UND, MN_UND, MN_BIT, MN_AND, MN_ROL, MN_UND,
    MN_PLP, MN_AND, MN_ROL, MN_UND, MN_BIT, MN_AND, MN_ROL, MN_UND,
    MN_BMI, MN_AND, MN_AND, MN_UND, MN_BIT, MN_AND, MN_ROL, MN_UND,
    MN_SEC, MN_AND, MN_DEC, MN_UND, MN_BIT, MN_AND, MN_ROL, MN_UND,
    MN_RTI, MN_EOR, MN_UND, MN_UND, MN_UND, MN_EOR, MN_LSR, MN_UND,
    MN_PHA, MN_EOR, MN_LSR, MN_UND, MN_JMP, MN_EOR, MN_LSR, MN_UND,
    MN_BVC, MN_EOR, MN_EOR, MN_UND, MN_UND, MN_EOR, MN_LSR, MN_UND,
    MN_CLI, MN_EOR, MN_PHY, MN_UND, MN_UND, MN_EOR, MN_LSR, MN_UND,
    MN_RTS, MN_ADC, MN_UND, MN_UND, MN_STZ, MN_ADC, MN_ROR, MN_UND,
    MN_PLA, MN_ADC, MN_ROR, MN_UND, MN_JMP, MN_ADC, MN_ROR, MN_UND,
    MN_BVS, MN_ADC, MN_ADC, MN_UND, MN_STZ, MN_ADC, MN_ROR, MN_UND,
    MN_SEI, MN_ADC, MN_PLY, MN_UND, MN_JMP, MN_ADC, MN_ROR, MN_UND,
    MN_BRA, MN_STA, MN_UND, MN_UND, MN_STY, MN_STA, MN_STX, MN_UND,
    MN_DEY, MN_BIT, MN_TXA, MN_UND, MN_STY, MN_STA, MN_STX, MN_UND,
    MN_BCC, MN_STA, MN_STA, MN_UND, MN_STY, MN_STA, MN_STX, MN_UND,
    MN_TYA, MN_STA, MN_TXS, MN_UND, MN_STZ, MN_STA, MN_STZ, MN_UND,
    MN_LDY, MN_LDA, MN_LDX, MN_UND, MN_LDY, MN_LDA, MN_LDX, MN_UND,
    MN_TAY, MN_LDA, MN_TAX, MN_UND, MN_LDY, MN_LDA, MN_LDX, MN_UND,
    MN_BCS, MN_LDA, MN_LDA, MN_UND, MN_LDY, MN_LDA, MN_LDX, MN_UND,
    MN_CLV, MN_LDA, MN_TSX, MN_UND, MN_LDY, MN_LDA, MN_LDX, MN_UND,
    MN_CPY, MN_CMP, MN_UND, MN_UND, MN_CPY, MN_CMP, MN_DEC, MN_UND,
    MN_INY, MN_CMP, MN_DEX, MN_WAI, MN_CPY, MN_CMP, MN_DEC, MN_UND,
    MN_BNE, MN_CMP, MN_CMP, MN_UND, MN_UND, MN_CMP, MN_DEC, MN_UND,
    MN_CLD, MN_CMP, MN_PHX, MN_STP, MN_UND, MN_CMP, MN_DEC, MN_UND,
    MN_CPX, MN_SBC, MN_UND, MN_UND, MN_CPX, MN_SBC, MN_INC, MN_UND,
    MN_INX, MN_SBC, MN_NOP, MN_UND, MN_CPX, MN_SBC, MN_INC, MN_UND,
    MN_BEQ, MN_SBC, MN_SBC, MN_UND, MN_UND, MN_SBC, MN_INC, MN_UND,
    MN_SED, MN_SBC, MN_PLX, MN_UND, MN_UND, MN_SBC, MN_INC, MN_UND
  };

  localparam amode_e ModeTab [256] = '{
    AM_IMP, AM_INDX, AM_IMP, AM_IMP, AM_ZP, AM_ZP, AM_ZP, AM_IMP,
    AM_IMP, AM_IMM, AM_IMPA, AM_IMP, AM_ABS, AM_ABS, AM_ABS, AM_IMP,
    AM_BRA, AM_INDY, AM_IND, AM_IMP, AM_ZP, AM_ZPX, AM_ZPX, AM_IMP,
    AM_IMP, AM_ABSY, AM_IMPA, AM_IMP, AM_ABS, AM_ABSX, AM_ABSX, AM_IMP,
    AM_ABS, AM_INDX, AM_IMP, AM_IMP, AM_ZP, AM_ZP, AM_ZP, AM_IMP,
    AM_IMP, AM_IMM, AM_IMPA, AM_IMP, AM_ABS, AM_ABS, AM_ABS, AM_IMP,
    AM_BRA, AM_INDY, AM_IND, AM_IMP, AM_ZPX, AM_ZPX, AM_ZPX, AM_IMP,
    AM_IMP, AM_ABSY, AM_IMPA, AM_IMP, AM_ABSX, AM_ABSX, AM_ABSX, AM_IMP,
    AM_IMP, AM_INDX, AM_IMP, AM_IMP, AM_ZP, AM_ZP, AM_ZP, AM_IMP,
    AM_IMP, AM_IMM, AM_IMPA, AM_IMP, AM_ABS, AM_ABS, AM_ABS, AM_IMP,
    AM_BRA, AM_INDY, AM_IND, AM_IMP, AM_ZP, AM_ZPX, AM_ZPX, AM_IMP,
    AM_IMP, AM_ABSY, AM_IMP, AM_IMP, AM_ABS, AM_ABSX, AM_ABSX, AM_IMP,
    AM_IMP, AM_INDX, AM_IMP, AM_IMP, AM_ZP, AM_ZP, AM_ZP, AM_IMP,
    AM_IMP, AM_IMM, AM_IMPA, AM_IMP, AM_IND16, AM_ABS, AM_ABS, AM_IMP,
    AM_BRA, AM_INDY, AM_IND, AM_IMP, AM_ZPX, AM_ZPX, AM_ZPX, AM_IMP,
    AM_IMP, AM_ABSY, AM_IMP, AM_IMP, AM_IND1X, AM_ABSX, AM_ABSX, AM_IMP,
    AM_BRA, AM_INDX, AM_IMP, AM_IMP, AM_ZP, AM_ZP, AM_ZP, AM_IMP,
    AM_IMP, AM_IMM, AM_IMP, AM_IMP, AM_ABS, AM_ABS, AM_ABS, AM_IMP,
    AM_BRA, AM_INDY, AM_IND, AM_IMP, AM_ZPX, AM_ZPX, AM_ZPY, AM_IMP,
    AM_IMP, AM_ABSY, AM_IMP, AM_IMP, AM_ABS, AM_ABSX, AM_ABSX, AM_IMP,
    AM_IMM, AM_INDX, AM_IMM, AM_IMP, AM_ZP, AM_ZP, AM_ZP, AM_IMP,
    AM_IMP, AM_IMM, AM_IMP, AM_IMP, AM_ABS, AM_ABS, AM_ABS, AM_IMP,
    AM_BRA, AM_INDY, AM_IND, AM_IMP, AM_ZPX, AM_ZPX, AM_ZPY, AM_IMP,
    AM_IMP, AM_ABSY, AM_IMP, AM_IMP, AM_ABSX, AM_ABSX, AM_ABSY, AM_IMP,
    AM_IMM, AM_INDX, AM_IMP, AM_IMP, AM_ZP, AM_ZP, AM_ZP, AM_IMP,
    AM_IMP, AM_IMM, AM_IMP, AM_IMP, AM_ABS, AM_ABS, AM_ABS, AM_IMP,
    AM_BRA, AM_INDY, AM_IND, AM_IMP, AM_ZP, AM_ZPX, AM_ZPX, AM_IMP,
    AM_IMP, AM_ABSY, AM_IMP, AM_IMP, AM_ABS, AM_ABSX, AM_ABSX, AM_IMP,
    AM_IMM, AM_INDX, AM_IMP, AM_IMP, AM_ZP, AM_ZP, AM_ZP, AM_IMP,
    AM_IMP, AM_IMM, AM_IMP, AM_IMP, AM_ABS, AM_ABS, AM_ABS, AM_IMP,
    AM_BRA, AM_INDY, AM_IND, AM_IMP, AM_ZP, AM_ZPX, AM_ZPX, AM_IMP,
    AM_IMP, AM_ABSY, AM_IMP, AM_IMP, AM_ABS, AM_ABSX, AM_ABSX, AM_IMP
  };

  function automatic logic [1:0] opnd_count(input logic [7:0] op);
    logic [4:0] m;
    m = ModeTab[op];
    if (m > LastOneOperand) begin
      return 2'd2;
    end else if (m > LastNoOperand) begin
      return 2'd1;
    end
    return 2'd0;
  endfunction

endpackage

`default_nettype wire

>>> hdl/cop_if.sv
`default_nettype none

interface cop_in_if;
  logic       valid;
  logic       ready;
  logic [7:0]  mem_byte;
  logic [15:0] byte_addr;

  modport source (output valid, output mem_byte, output byte_addr, input ready);
  modport sink (input valid, input mem_byte, input byte_addr, output ready);
endinterface

interface cop_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] instr_addr;
  logic [7:0]  opcode_value;
  logic [6:0]  mnemonic_id;
  logic [4:0]  addr_mode;
  logic [7:0]  operand_lo;
  logic [7:0]  operand_hi;
  logic [1:0]  instr_length;
  logic [15:0] branch_target;
  logic [15:0] next_addr;

  modport source (
    output valid, output instr_addr, output opcode_value, output mnemonic_id,
    output addr_mode, output operand_lo, output operand_hi, output instr_length,
    output branch_target, output next_addr, input ready
  );
  modport sink (
    input valid, input instr_addr, input opcode_value, input mnemonic_id,
    input addr_mode, input operand_lo, input operand_hi, input instr_length,
    input branch_target, input next_addr, output ready
  );
endinterface

`default_nettype wire

>>> hdl/cpu_opcode_predecoder_top.sv
// Channel  Dir  Word
// in_i     in   mem_byte[7:0], byte_addr[15:0]
// out_o    out  instr_addr, opcode_value, mnemonic_id, addr_mode, operand_lo,
//                operand_hi, instr_length, branch_target, next_addr
//
// One byte is accepted every cycle while in_i.ready is high; a decoded word
// leaves through the record and output registers after the last byte of its instruction.
// The mode table is read combinationally in both stages, the mnemonic table only in the output stage.
// Reset clears the pending byte count and both valid flags.
// A stall on out_o stops in_i only once both registers are full.
`default_nettype none

module cpu_opcode_predecoder_top (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cop_in_if.sink     in_i,
  cop_out_if.source  out_o
);

  cop_pkg::rec_t rec;
  logic          rec_valid;
  logic          rec_ready;

  cop_collect u_collect (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .rec_o       (rec),
    .rec_valid_o (rec_valid),
    .rec_ready_i (rec_ready)
  );

  cop_format u_format (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (rec),
    .rec_valid_i (rec_valid),
    .rec_ready_o (rec_ready),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

>>> hdl/cop_collect.sv
`default_nettype none
`include "cpu_opcode_predecoder_top_defines.svh"

module cop_collect (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  cop_in_if.sink            in_i,
  output cop_pkg::rec_t     rec_o,
  output logic              rec_valid_o,
  input  wire logic         rec_ready_i
);

  logic [1:0]    pending_q, pending_d;
  logic [7:0]    held_op_q, held_op_d;
  logic [15:0]   held_addr_q, held_addr_d;
  logic [7:0]    held_lo_q, held_lo_d;
  cop_pkg::rec_t rec_q, rec_d;
  logic          rec_valid_q, rec_valid_d;
  logic          in_fire;
  logic          emit;
  logic [1:0]    new_count;
  logic          held_two;

  assign in_i.ready  = !rec_valid_q || rec_ready_i;
  assign in_fire     = in_i.valid && in_i.ready;
  assign new_count   = cop_pkg::opnd_count(in_i.mem_byte);
  assign held_two    = (cop_pkg::opnd_count(held_op_q) == 2'd2);
  assign rec_o       = rec_q;
  assign rec_valid_o = rec_valid_q;

  always_comb begin
    pending_d   = pending_q;
    held_op_d   = held_op_q;
    held_addr_d = held_addr_q;
    held_lo_d   = held_lo_q;
    rec_d       = rec_q;
    emit        = 1'b0;
    if (in_fire) begin
      case (pending_q)
        2'd2: begin
          held_lo_d = in_i.mem_byte;
          pending_d = 2'd1;
        end
        2'd1: begin
          pending_d    = 2'd0;
          emit         = 1'b1;
          rec_d.opcode = held_op_q;
          rec_d.addr   = held_addr_q;
          if (held_two) begin
            rec_d.operand_lo = held_lo_q;
            rec_d.operand_hi = in_i.mem_byte;
          end else begin
            rec_d.operand_lo = in_i.mem_byte;
            rec_d.operand_hi = 8'd0;
          end
        end
        default: begin
          held_op_d        = in_i.mem_byte;
          held_addr_d      = in_i.byte_addr;
          held_lo_d        = 8'd0;
          pending_d        = new_count;
          emit             = (new_count == 2'd0);
          rec_d.opcode     = in_i.mem_byte;
          rec_d.addr       = in_i.byte_addr;
          rec_d.operand_lo = 8'd0;
          rec_d.operand_hi = 8'd0;
        end
      endcase
    end
  end

  always_comb begin
    rec_valid_d = rec_valid_q && !rec_ready_i;
    if (emit) begin
      rec_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= 2'd0;
      rec_valid_q <= 1'b0;
    end else begin
      pending_q   <= pending_d;
      rec_valid_q <= rec_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_op_q   <= held_op_d;
    held_addr_q <= held_addr_d;
    held_lo_q   <= held_lo_d;
    if (emit) begin
      rec_q <= rec_d;
    end
  end

  `COP_ASSERT_ALWAYS(a_pending_legal, (!rst_ni || pending_q != 2'd3))
  `COP_ASSERT(a_first_operand_held, (in_fire && pending_q == 2'd2) |=> pending_q == 2'd1)
  `COP_ASSERT(a_rec_holds, (rec_valid_q && !rec_ready_i) |=> (rec_valid_q && $stable(rec_q)))

endmodule

`default_nettype wire

>>> hdl/cop_format.sv
`default_nettype none
`include "cpu_opcode_predecoder_top_defines.svh"

module cop_format (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cop_pkg::rec_t rec_i,
  input  wire logic          rec_valid_i,
  output logic               rec_ready_o,
  cop_out_if.source          out_o
);

  logic             out_valid_q;
  logic             rec_fire;
  cop_pkg::amode_e  mode;
  cop_pkg::mnem_e   mnem;
  logic [1:0]       len;
  logic [15:0]      target;
  logic [15:0]      next;

  logic [15:0] addr_q;
  logic [7:0]  op_q;
  logic [6:0]  mnem_q;
  logic [4:0]  mode_q;
  logic [7:0]  lo_q;
  logic [7:0]  hi_q;
  logic [1:0]  len_q;
  logic [15:0] target_q;
  logic [15:0] next_q;

  assign rec_ready_o = !out_valid_q || out_o.ready;
  assign rec_fire    = rec_valid_i && rec_ready_o;

  always_comb begin
    mode   = cop_pkg::ModeTab[rec_i.opcode];
    mnem   = cop_pkg::MnemTab[rec_i.opcode];
    len    = 2'd1 + cop_pkg::opnd_count(rec_i.opcode);
    target = 16'd0;
    if (mode == cop_pkg::AM_BRA) begin
      target = rec_i.addr + 16'd2 + {{8{rec_i.operand_lo[7]}}, rec_i.operand_lo};
    end
    next = rec_i.addr + {14'd0, len};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rec_ready_o) begin
      out_valid_q <= rec_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_fire) begin
      addr_q   <= rec_i.addr;
      op_q     <= rec_i.opcode;
      mnem_q   <= mnem;
      mode_q   <= mode;
      lo_q     <= rec_i.operand_lo;
      hi_q     <= rec_i.operand_hi;
      len_q    <= len;
      target_q <= target;
      next_q   <= next;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.instr_addr    = addr_q;
  assign out_o.opcode_value  = op_q;
  assign out_o.mnemonic_id   = mnem_q;
  assign out_o.addr_mode     = mode_q;
  assign out_o.operand_lo    = lo_q;
  assign out_o.operand_hi    = hi_q;
  assign out_o.instr_length  = len_q;
  assign out_o.branch_target = target_q;
  assign out_o.next_addr     = next_q;

  `COP_ASSERT(a_target_only_rel, (out_valid_q && mode_q != cop_pkg::AM_BRA) |-> target_q == 16'd0)
  `COP_ASSERT(a_short_no_operand, (out_valid_q && len_q == 2'd1) |-> (lo_q == 8'd0 && hi_q == 8'd0))

endmodule

`default_nettype wire
